### hdl/ldcf_pkg.sv
// ----------------------------------------------------------------------------
// LED driver command framer package
// Shared types, codes, constants and the segment table of the framer.
// ----------------------------------------------------------------------------
package ldcf_pkg;

    localparam int CMD_W = 3;
    localparam int POS_W = 2;
    localparam int VALUE_W = 16;
    localparam int BYTE_W = 8;
    localparam int LEVEL_W = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int STEP_W = 4;

    localparam logic [BYTE_W-1:0] FIXED_CMD_RESET = 8'h44;
    localparam logic [BYTE_W-1:0] AUTO_CMD_RESET = 8'h40;
    localparam logic [BYTE_W-1:0] BASE_CMD_RESET = 8'hC0;
    localparam logic [BYTE_W-1:0] CTRL_RESET = 8'h8A;
    localparam logic [BYTE_W-1:0] CTRL_ON = 8'h88;
    localparam logic [BYTE_W-1:0] CTRL_OFF = 8'h80;
    localparam logic [2:0] MAX_BRIGHT = 3'd7;
    localparam logic [9:0] INT_LIMIT = 10'd999;
    localparam logic [POS_W-1:0] POINT_SLOT = 2'd3;
    localparam logic [BYTE_W-1:0] SEG_ZERO = 8'h3f;

    localparam logic [STEP_W-1:0] LAST_FIXED = 4'd3;
    localparam logic [STEP_W-1:0] LAST_INTEGER = 4'd5;
    localparam logic [STEP_W-1:0] LAST_CLEAR = 4'd9;
    localparam logic [STEP_W-1:0] LAST_OFF = 4'd0;
    localparam logic [STEP_W-1:0] CLEAR_SPLIT = 4'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_DIGIT = 3'd0,
        CMD_INTEGER = 3'd1,
        CMD_POINT = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_BRIGHT = 3'd4,
        CMD_OFF = 3'd5
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FIXED_CMD = 2'd0,
        REG_AUTO_CMD = 2'd1,
        REG_BASE_CMD = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_FIXED,
        KIND_INTEGER,
        KIND_CLEAR,
        KIND_OFF
    } kind_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] digit_position;
        logic [VALUE_W-1:0] value;
        logic [BYTE_W-1:0] point_byte;
        logic [LEVEL_W-1:0] brightness_level;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] bus_byte;
        logic start_before;
        logic stop_after;
        logic last;
    } out_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] hundreds;
        logic [BYTE_W-1:0] tens;
        logic [BYTE_W-1:0] ones;
    } seg_digits_t;

    function automatic logic [BYTE_W-1:0] seg_of(input logic [VALUE_W-1:0] idx);
        logic [BYTE_W-1:0] seg;
        seg = 8'h00;
        if (idx < 16'd22)
        begin
            case (idx[4:0])
                5'd0: seg = 8'h3f;
                5'd1: seg = 8'h06;
                5'd2: seg = 8'h5b;
                5'd3: seg = 8'h4f;
                5'd4: seg = 8'h66;
                5'd5: seg = 8'h6d;
                5'd6: seg = 8'h7d;
                5'd7: seg = 8'h07;
                5'd8: seg = 8'h7f;
                5'd9: seg = 8'h6f;
                5'd10: seg = 8'h77;
                5'd11: seg = 8'h7c;
                5'd12: seg = 8'h39;
                5'd13: seg = 8'h5e;
                5'd14: seg = 8'h79;
                5'd15: seg = 8'h71;
                5'd16: seg = 8'h00;
                5'd17: seg = 8'h63;
                5'd18: seg = 8'h5c;
                5'd19: seg = 8'h01;
                5'd20: seg = 8'h40;
                5'd21: seg = 8'h08;
                default: seg = 8'h00;
            endcase
        end
        return seg;
    endfunction

endpackage

### hdl/ldcf_decimal.sv
// ----------------------------------------------------------------------------
// LED driver command framer decimal digits
// Saturates a value to 999 and returns its three digits as segment bytes.
// ----------------------------------------------------------------------------
module ldcf_decimal
    import ldcf_pkg::*;
(
    input  logic [VALUE_W-1:0] value,
    output seg_digits_t        digits
);

    logic [9:0]  sat;
    logic [15:0] hund_prod;
    logic [3:0]  hund;
    logic [6:0]  rem;
    logic [13:0] tens_prod;
    logic [3:0]  tens;
    logic [3:0]  ones;

    // Division by 100 and by 10 uses reciprocal products exact over the range.
    always_comb
    begin
        sat = (value > VALUE_W'(INT_LIMIT)) ? INT_LIMIT : value[9:0];
        hund_prod = 16'(sat) * 16'd41;
        hund = hund_prod[15:12];
        rem = 7'(sat - 10'(hund) * 10'd100);
        tens_prod = 14'(rem) * 14'd103;
        tens = tens_prod[13:10];
        ones = 4'(rem - 7'(tens) * 7'd10);
        digits.hundreds = seg_of(VALUE_W'(hund));
        digits.tens = seg_of(VALUE_W'(tens));
        digits.ones = seg_of(VALUE_W'(ones));
    end

endmodule

### hdl/led_driver_command_framer.sv
// ----------------------------------------------------------------------------
// LED driver command framer
// Turns display commands into framed bytes for a two-wire seven-segment
// LED driver, one byte per output item.
// ----------------------------------------------------------------------------
// Each accepted command is held in an item register and its bytes leave one
// per cycle through a single output register while the output side does not
// stall: a digit or decimal-point command gives 4 bytes, an integer command
// 6, a clear command 10 and an off command 1. The next command is taken in
// the same cycle that the last byte of the current one is registered.
// Brightness commands and unused codes give no bytes and leave the item
// register empty. The byte rate is set by the one output register, which
// moves one byte per cycle while it is empty or out_ready is high.
module led_driver_command_framer
    import ldcf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data
);

    logic [BYTE_W-1:0] fixed_cmd_reg;
    logic [BYTE_W-1:0] auto_cmd_reg;
    logic [BYTE_W-1:0] base_cmd_reg;
    logic [BYTE_W-1:0] ctrl_reg;
    logic [BYTE_W-1:0] ctrl_next;

    logic              item_valid_reg;
    logic              item_valid_next;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic [POS_W-1:0]  slot_reg;
    logic [POS_W-1:0]  slot_next;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;
    seg_digits_t       digits_reg;
    seg_digits_t       digits_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_reg;

    seg_digits_t       in_digits;
    logic              in_fire;
    logic              out_advance;
    logic              byte_fire;
    logic              last_step;
    logic [STEP_W-1:0] final_step;
    out_item_t         byte_item;
    logic [2:0]        level;

    ldcf_decimal u_decimal
    (
        .value  (in_data.value),
        .digits (in_digits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_cmd_reg <= FIXED_CMD_RESET;
            auto_cmd_reg <= AUTO_CMD_RESET;
            base_cmd_reg <= BASE_CMD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIXED_CMD: fixed_cmd_reg <= cfg_data;
                REG_AUTO_CMD: auto_cmd_reg <= cfg_data;
                REG_BASE_CMD: base_cmd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (kind_reg)
            KIND_FIXED: final_step = LAST_FIXED;
            KIND_INTEGER: final_step = LAST_INTEGER;
            KIND_CLEAR: final_step = LAST_CLEAR;
            KIND_OFF: final_step = LAST_OFF;
            default: final_step = LAST_OFF;
        endcase
        last_step = (step_reg == final_step);
        out_advance = !out_valid_reg || out_ready;
        byte_fire = item_valid_reg && out_advance;
        in_ready = !item_valid_reg || (byte_fire && last_step);
        in_fire = in_valid && in_ready;
    end

    // The first four bytes of a clear command form a fixed-address frame,
    // the rest an integer frame.
    always_comb
    begin
        logic              use_fixed;
        logic [STEP_W-1:0] sub;
        use_fixed = (kind_reg == KIND_FIXED)
                    || ((kind_reg == KIND_CLEAR) && (step_reg < CLEAR_SPLIT));
        sub = (kind_reg == KIND_CLEAR && !use_fixed) ? step_reg - CLEAR_SPLIT : step_reg;
        byte_item = '{bus_byte: ctrl_reg, start_before: 1'b1, stop_after: 1'b1,
                      last: last_step};
        if (kind_reg == KIND_OFF)
        begin
            byte_item.bus_byte = ctrl_reg;
        end
        else if (use_fixed)
        begin
            case (sub)
                4'd0: byte_item.bus_byte = fixed_cmd_reg;
                4'd1:
                begin
                    byte_item.bus_byte = base_cmd_reg + BYTE_W'(slot_reg);
                    byte_item.stop_after = 1'b0;
                end
                4'd2:
                begin
                    byte_item.bus_byte = data_reg;
                    byte_item.start_before = 1'b0;
                end
                default: byte_item.bus_byte = ctrl_reg;
            endcase
        end
        else
        begin
            case (sub)
                4'd0: byte_item.bus_byte = auto_cmd_reg;
                4'd1:
                begin
                    byte_item.bus_byte = base_cmd_reg;
                    byte_item.stop_after = 1'b0;
                end
                4'd2:
                begin
                    byte_item.bus_byte = digits_reg.hundreds;
                    byte_item.start_before = 1'b0;
                    byte_item.stop_after = 1'b0;
                end
                4'd3:
                begin
                    byte_item.bus_byte = digits_reg.tens;
                    byte_item.start_before = 1'b0;
                    byte_item.stop_after = 1'b0;
                end
                4'd4:
                begin
                    byte_item.bus_byte = digits_reg.ones;
                    byte_item.start_before = 1'b0;
                end
                default: byte_item.bus_byte = ctrl_reg;
            endcase
        end
    end

    always_comb
    begin
        level = in_data.brightness_level[3] ? MAX_BRIGHT : in_data.brightness_level[2:0];
        ctrl_next = ctrl_reg;
        item_valid_next = item_valid_reg;
        kind_next = kind_reg;
        slot_next = slot_reg;
        data_next = data_reg;
        digits_next = digits_reg;
        step_next = step_reg;
        if (byte_fire)
        begin
            step_next = step_reg + STEP_W'(1);
            if (last_step)
            begin
                item_valid_next = 1'b0;
            end
        end
        if (in_fire)
        begin
            step_next = '0;
            item_valid_next = 1'b0;
            unique case (in_data.command)
                CMD_DIGIT:
                begin
                    item_valid_next = 1'b1;
                    kind_next = KIND_FIXED;
                    slot_next = in_data.digit_position;
                    data_next = seg_of(in_data.value);
                end
                CMD_INTEGER:
                begin
                    item_valid_next = 1'b1;
                    kind_next = KIND_INTEGER;
                    digits_next = in_digits;
                end
                CMD_POINT:
                begin
                    item_valid_next = 1'b1;
                    kind_next = KIND_FIXED;
                    slot_next = POINT_SLOT;
                    data_next = in_data.point_byte;
                end
                CMD_CLEAR:
                begin
                    item_valid_next = 1'b1;
                    kind_next = KIND_CLEAR;
                    slot_next = POINT_SLOT;
                    data_next = '0;
                    digits_next = '{hundreds: SEG_ZERO, tens: SEG_ZERO, ones: SEG_ZERO};
                end
                CMD_BRIGHT:
                begin
                    ctrl_next = CTRL_ON + BYTE_W'(level);
                end
                CMD_OFF:
                begin
                    item_valid_next = 1'b1;
                    kind_next = KIND_OFF;
                    ctrl_next = CTRL_OFF;
                end
                default: ;
            endcase
        end
        if (byte_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= CTRL_RESET;
            item_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg <= KIND_FIXED;
            step_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
            item_valid_reg <= item_valid_next;
            out_valid_reg <= out_valid_next;
            kind_reg <= kind_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        data_reg <= data_next;
        digits_reg <= digits_next;
        if (byte_fire)
        begin
            out_reg <= byte_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule
